// ===== sv/lpcs_pkg.sv =====
// Shared types and codes for the primary link state machine.
package lpcs_pkg;

	localparam int unsigned RetryWidth = 8;

	typedef enum logic [3:0] {
		OP_SEND_CONF     = 4'd0,
		OP_SEND_UNCONF   = 4'd1,
		OP_TX_DONE       = 4'd2,
		OP_ACK           = 4'd3,
		OP_NACK          = 4'd4,
		OP_LINK_STATUS   = 4'd5,
		OP_NOT_SUPPORTED = 4'd6,
		OP_TIMEOUT       = 4'd7,
		OP_FAILURE       = 4'd8
	} opcode_t;

	typedef enum logic [2:0] {
		ST_NOT_RESET = 3'd0,
		ST_RL_TXWAIT = 3'd1,
		ST_CD_TXWAIT = 3'd2,
		ST_RESET     = 3'd3,
		ST_RL_WAIT   = 3'd4,
		ST_CD_WAIT   = 3'd5,
		ST_UN_TX_NR  = 3'd6,
		ST_UN_TX_R   = 3'd7
	} link_state_t;

	typedef enum logic [1:0] {
		FR_NONE   = 2'd0,
		FR_RESET  = 2'd1,
		FR_CONF   = 2'd2,
		FR_UNCONF = 2'd3
	} frame_cmd_t;

	typedef enum logic [1:0] {
		TM_NONE   = 2'd0,
		TM_START  = 2'd1,
		TM_CANCEL = 2'd2
	} timer_cmd_t;

	typedef struct packed {
		logic [3:0] opcode;
		logic       tx_success;
		logic       rcv_buffer_full;
		logic       more_segments;
	} lpcs_event_t;

	typedef struct packed {
		link_state_t           state;
		logic [RetryWidth-1:0] retries_left;
		logic                  write_fcb;
	} lpcs_ctx_t;

	typedef struct packed {
		frame_cmd_t frame_cmd;
		logic       frame_fcb;
		timer_cmd_t timer_cmd;
		logic       result_valid;
		logic       result_ok;
		logic       unexpected;
		lpcs_ctx_t  ctx;
	} lpcs_result_t;

endpackage

// ===== sv/lpcs_step.sv =====
// Next-state and command logic for one link event.
module lpcs_step (
	input  lpcs_pkg::lpcs_event_t              ev,
	input  lpcs_pkg::lpcs_ctx_t                cur,
	input  logic [lpcs_pkg::RetryWidth-1:0]    retry_limit,
	output lpcs_pkg::lpcs_result_t             res
);
	import lpcs_pkg::*;

	logic have_retry;
	logic [RetryWidth-1:0] retry_dec;

	assign have_retry = (cur.retries_left != '0);
	assign retry_dec  = cur.retries_left - RetryWidth'(1);

	always_comb begin
		res              = '0;
		res.frame_cmd    = FR_NONE;
		res.timer_cmd    = TM_NONE;
		res.ctx          = cur;

		unique case (cur.state)
			ST_NOT_RESET, ST_RESET: begin
				if (ev.opcode == OP_SEND_CONF) begin
					res.ctx.retries_left = retry_limit;
					if (cur.state == ST_NOT_RESET) begin
						res.frame_cmd = FR_RESET;
						res.ctx.state = ST_RL_TXWAIT;
					end else begin
						res.frame_cmd = FR_CONF;
						res.frame_fcb = cur.write_fcb;
						res.ctx.state = ST_CD_TXWAIT;
					end
				end else if (ev.opcode == OP_SEND_UNCONF) begin
					res.frame_cmd = FR_UNCONF;
					res.ctx.state = (cur.state == ST_NOT_RESET) ? ST_UN_TX_NR : ST_UN_TX_R;
				end else begin
					res.unexpected = 1'b1;
				end
			end
			ST_RL_TXWAIT, ST_CD_TXWAIT: begin
				if (ev.opcode == OP_TX_DONE) begin
					if (ev.tx_success) begin
						res.timer_cmd = TM_START;
						res.ctx.state = (cur.state == ST_RL_TXWAIT) ? ST_RL_WAIT : ST_CD_WAIT;
					end else begin
						res.result_valid = 1'b1;
						res.ctx.state = (cur.state == ST_RL_TXWAIT) ? ST_NOT_RESET : ST_RESET;
					end
				end else begin
					res.unexpected = 1'b1;
				end
			end
			ST_RL_WAIT: begin
				if (ev.opcode == OP_ACK) begin
					res.ctx.write_fcb = 1'b1;
					res.timer_cmd     = TM_CANCEL;
					res.frame_cmd     = FR_CONF;
					res.frame_fcb     = 1'b1;
					res.ctx.state     = ST_CD_TXWAIT;
				end else if (ev.opcode == OP_TIMEOUT) begin
					if (have_retry) begin
						res.ctx.retries_left = retry_dec;
						res.frame_cmd        = FR_RESET;
						res.ctx.state        = ST_RL_TXWAIT;
					end else begin
						res.result_valid = 1'b1;
						res.ctx.state    = ST_NOT_RESET;
					end
				end else if (ev.opcode == OP_FAILURE) begin
					res.timer_cmd    = TM_CANCEL;
					res.result_valid = 1'b1;
					res.ctx.state    = ST_NOT_RESET;
				end else begin
					res.unexpected = 1'b1;
				end
			end
			ST_CD_WAIT: begin
				if (ev.opcode == OP_ACK) begin
					res.ctx.write_fcb = ~cur.write_fcb;
					res.timer_cmd     = TM_CANCEL;
					if (ev.more_segments) begin
						res.frame_cmd = FR_CONF;
						res.frame_fcb = ~cur.write_fcb;
						res.ctx.state = ST_CD_TXWAIT;
					end else begin
						res.result_valid = 1'b1;
						res.result_ok    = 1'b1;
						res.ctx.state    = ST_RESET;
					end
				end else if (ev.opcode == OP_NACK) begin
					res.timer_cmd = TM_CANCEL;
					if (ev.rcv_buffer_full) begin
						res.result_valid = 1'b1;
						res.ctx.state    = ST_NOT_RESET;
					end else begin
						res.ctx.retries_left = retry_limit;
						res.frame_cmd        = FR_RESET;
						res.ctx.state        = ST_RL_TXWAIT;
					end
				end else if (ev.opcode == OP_TIMEOUT) begin
					if (have_retry) begin
						res.ctx.retries_left = retry_dec;
						res.frame_cmd        = FR_CONF;
						res.frame_fcb        = cur.write_fcb;
						res.ctx.state        = ST_CD_TXWAIT;
					end else begin
						res.result_valid = 1'b1;
						res.ctx.state    = ST_NOT_RESET;
					end
				end else if (ev.opcode == OP_FAILURE) begin
					res.timer_cmd    = TM_CANCEL;
					res.result_valid = 1'b1;
					res.ctx.state    = ST_NOT_RESET;
				end else begin
					res.unexpected = 1'b1;
				end
			end
			ST_UN_TX_NR, ST_UN_TX_R: begin
				if (ev.opcode == OP_TX_DONE) begin
					if (ev.tx_success && ev.more_segments) begin
						res.frame_cmd = FR_UNCONF;
					end else begin
						res.result_valid = 1'b1;
						res.result_ok    = ev.tx_success;
						res.ctx.state = (cur.state == ST_UN_TX_NR) ? ST_NOT_RESET : ST_RESET;
					end
				end else begin
					res.unexpected = 1'b1;
				end
			end
			default: begin
				res.unexpected = 1'b1;
			end
		endcase
	end

endmodule

// ===== sv/link_primary_confirmed_send_fsm.sv =====
// Top level of the primary link state machine: event and result registers and context state.
// This block tracks the primary side of a link layer: it takes one link event per transfer
// (send confirmed, send unconfirmed, transmit done, ack, nack, link status, not supported,
// timeout, failure) and returns exactly one result per event, carrying the frame to queue,
// its frame count bit, a timer command, the outcome of a finished send, an unexpected-event
// flag, the new link state and the remaining retry count. The block sustains one event per
// clock cycle while the result side does not stall; an event passes through the event
// register and then the result register. The link context (state, retry count, frame count
// bit) is updated at the same edge that loads the result register, so the next event already
// sees it. A stall on the result side holds the result register and, if the event register
// is also full, raises in_stall. The retry limit is loaded over the configuration channel,
// which is always ready; it should only be written while no events are in flight. After
// reset the link is not reset, no retries remain, the frame count bit is one and the retry
// limit is zero.
module link_primary_confirmed_send_fsm (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lpcs_pkg::RetryWidth-1:0]    cfg_data,
	// event channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [3:0]                         opcode,
	input  logic                               tx_success,
	input  logic                               rcv_buffer_full,
	input  logic                               more_segments,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         frame_cmd,
	output logic                               frame_fcb,
	output logic [1:0]                         timer_cmd,
	output logic                               result_valid,
	output logic                               result_ok,
	output logic                               unexpected,
	output logic [2:0]                         link_state,
	output logic [lpcs_pkg::RetryWidth-1:0]    retries_left_out
);
	import lpcs_pkg::*;

	logic [RetryWidth-1:0] retry_limit_q;
	lpcs_ctx_t             ctx_q;

	logic                  valid_s1;
	lpcs_event_t           ev_s1;
	logic                  valid_s2;
	lpcs_result_t          res_s2;

	lpcs_result_t          step_res;
	logic                  adv_s1;
	logic                  take_in;

	// The result register can load whenever it is empty or its content is leaving.
	assign adv_s1    = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign take_in   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	lpcs_step u_step (
		.ev          (ev_s1),
		.cur         (ctx_q),
		.retry_limit (retry_limit_q),
		.res         (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q      <= '0;
			ctx_q.state        <= ST_NOT_RESET;
			ctx_q.retries_left <= '0;
			ctx_q.write_fcb    <= 1'b1;
			valid_s1           <= 1'b0;
			valid_s2           <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				retry_limit_q <= cfg_data;
			end
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				ctx_q    <= step_res.ctx;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset; their valid bits qualify them.
	always_ff @(posedge clk) begin
		if (take_in) begin
			ev_s1.opcode          <= opcode;
			ev_s1.tx_success      <= tx_success;
			ev_s1.rcv_buffer_full <= rcv_buffer_full;
			ev_s1.more_segments   <= more_segments;
		end
		if (adv_s1) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid        = valid_s2;
	assign frame_cmd        = res_s2.frame_cmd;
	assign frame_fcb        = res_s2.frame_fcb;
	assign timer_cmd        = res_s2.timer_cmd;
	assign result_valid     = res_s2.result_valid;
	assign result_ok        = res_s2.result_ok;
	assign unexpected       = res_s2.unexpected;
	assign link_state       = res_s2.ctx.state;
	assign retries_left_out = res_s2.ctx.retries_left;

	// An ignored event must leave the link context untouched.
	a_unexpected_keeps_ctx : assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && step_res.unexpected) |=> $stable(ctx_q))
		else $error("unexpected event changed the link context");

	// An ignored event issues no commands and no send result.
	a_unexpected_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && unexpected) |-> (frame_cmd == FR_NONE && timer_cmd == TM_NONE
			&& !result_valid))
		else $error("unexpected event produced a command");

	// The frame count bit is only meaningful with confirmed data.
	a_fcb_only_conf : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_fcb) |-> (frame_cmd == FR_CONF))
		else $error("frame count bit set without confirmed data");

	// The reported state of a result is the context the next event starts from.
	a_state_matches_ctx : assert property (@(posedge clk) disable iff (!arst_n)
		$past(adv_s1) |-> (link_state == ctx_q.state
			&& retries_left_out == ctx_q.retries_left))
		else $error("result state differs from link context");

endmodule
